@@ rtl/core/leb_pkg.sv @@
// Shared types and constants for the LEB128 stream decoder.
// No dependencies; compile first.
package leb_pkg;

	localparam int unsigned ValueWidth = 64;
	localparam int unsigned PosWidth   = 7;

	// byte layout
	localparam int unsigned ContBit = 7;
	localparam int unsigned SignBit = 6;
	localparam logic [6:0]  PayloadMask = 7'b1111111;

	// bit limit range
	localparam logic [PosWidth-1:0] LimitMin = 7'd1;
	localparam logic [PosWidth-1:0] LimitMax = 7'd64;
	localparam logic [PosWidth-1:0] GroupBits = 7'd7;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_PADDING  = 2'd1,
		ST_TOO_LONG = 2'd2
	} status_t;

	// decoder state carried between bytes
	typedef struct packed {
		logic [ValueWidth-1:0] acc;
		logic [PosWidth-1:0]   bit_pos;
		logic                  sgn;
		logic [PosWidth-1:0]   limit;
	} dec_state_t;

	// outcome of one byte
	typedef struct packed {
		logic                  emit;
		logic [ValueWidth-1:0] value;
		status_t               status;
		dec_state_t            next;
	} step_out_t;

endpackage

@@ rtl/core/leb_in_if.sv @@
// Byte request channel of the LEB128 decoder: valid/ready plus payload.
// No dependencies.
interface leb_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       is_signed;
	logic [6:0] max_bits;

	modport source (output valid, output data_byte, output is_signed, output max_bits,
		input ready);
	modport sink (input valid, input data_byte, input is_signed, input max_bits,
		output ready);
endinterface

@@ rtl/core/leb_out_if.sv @@
// Result request channel of the LEB128 decoder: valid/ready plus payload.
// No dependencies.
interface leb_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] value;
	logic [1:0]  status;

	modport source (output valid, output value, output status, input ready);
	modport sink (input valid, input value, input status, output ready);
endinterface

@@ rtl/core/leb_step.sv @@
// Combinational decode of one LEB128 byte against the running state.
// Depends on leb_pkg.
module leb_step (
	input  logic [7:0]          data_byte,
	input  logic                is_signed,
	input  logic [6:0]          max_bits,
	input  leb_pkg::dec_state_t cur,
	output leb_pkg::step_out_t  res
);
	import leb_pkg::*;

	logic                  first;
	logic [PosWidth-1:0]   lim;
	logic                  sgn;
	logic [ValueWidth-1:0] acc_base;
	logic [ValueWidth-1:0] acc_new;
	logic [PosWidth-1:0]   after;
	logic [PosWidth-1:0]   excess;
	logic [2:0]            top;
	logic [7:0]            mask_w;
	logic [6:0]            mask;
	logic [6:0]            pad;
	logic                  neg;
	logic                  over;
	logic                  pad_bad;
	logic                  cont;
	logic                  too_long;
	logic [ValueWidth-1:0] ext_val;

	// pick latched or fresh number parameters
	always_comb begin
		first = (cur.bit_pos == '0);
		if (max_bits < LimitMin) begin
			lim = LimitMin;
		end else if (max_bits > LimitMax) begin
			lim = LimitMax;
		end else begin
			lim = max_bits;
		end
		if (!first) begin
			lim = cur.limit;
		end
		sgn      = first ? is_signed : cur.sgn;
		acc_base = first ? '0 : cur.acc;
	end

	// place payload, check padding of the byte crossing the limit and flag too many bytes
	always_comb begin
		acc_new = acc_base | ({57'b0, data_byte[6:0] & PayloadMask} << cur.bit_pos[5:0]);
		after   = cur.bit_pos + GroupBits;
		over    = (after > lim);
		excess  = after - lim;
		top     = 3'(7'd6 - excess);
		mask_w  = 8'hFF << ({1'b0, top} + 4'd1);
		mask    = mask_w[6:0] & PayloadMask;
		pad     = data_byte[6:0] & mask;
		neg     = sgn && data_byte[top];
		pad_bad = over && (neg ? (pad != mask) : (pad != '0));
		cont    = data_byte[ContBit];
		too_long = cont && (after >= lim);
	end

	// sign-extend a finished signed number
	always_comb begin
		ext_val = acc_new;
		if (sgn && data_byte[SignBit] && (after < LimitMax)) begin
			ext_val = acc_new | ({ValueWidth{1'b1}} << after[5:0]);
		end
	end

	// assemble the outcome and next state
	always_comb begin
		res.emit   = pad_bad || too_long || !cont;
		res.status = ST_OK;
		res.value  = ext_val;
		if (pad_bad) begin
			res.status = ST_PADDING;
			res.value  = '0;
		end else if (too_long) begin
			res.status = ST_TOO_LONG;
			res.value  = '0;
		end
		res.next.sgn   = sgn;
		res.next.limit = lim;
		if (res.emit) begin
			res.next.acc     = '0;
			res.next.bit_pos = '0;
		end else begin
			res.next.acc     = acc_new;
			res.next.bit_pos = after;
		end
	end
endmodule

@@ rtl/core/leb128_stream_decoder_core.sv @@
// Top level of the LEB128 stream decoder: input stage, decode, result register.
// Depends on leb_pkg, leb_in_if, leb_out_if and leb_step.
//
// Usage:
//   byte_ch carries one encoded byte per request together with is_signed and
//   max_bits; the flag and limit are taken from the first byte of a number.
//   result_ch carries one request per finished or failed number: value and
//   status (ok, bad padding, too many bytes). Bytes inside a number give no
//   result.
//   Path: the byte that ends its number is registered in the input register,
//   and its result in the result register; the decode between the two
//   registers is a single pass of shift, mask and OR into the 64-bit
//   accumulator. Throughput: one byte per cycle outside a stall.
//   Stall: while a result waits on result_ch, bytes that continue a number
//   still flow; a byte that produces a further result holds in the input
//   register until the result register frees, and byte_ch.ready drops.
//   Reset (arst_n low) empties both registers and clears the decoder state
//   (limit field 64) to await the first byte of a number.
module leb128_stream_decoder_core (
	input  logic clk,
	input  logic arst_n,
	leb_in_if.sink   byte_ch,
	leb_out_if.source result_ch
);
	import leb_pkg::*;

	logic       valid_s1;
	logic [7:0] data_byte_s1;
	logic       is_signed_s1;
	logic [6:0] max_bits_s1;

	dec_state_t state_q;
	step_out_t  step;
	logic       s1_adv;
	logic       byte_acc;

	logic                  out_valid_q;
	logic [ValueWidth-1:0] value_q;
	status_t               status_q;

	leb_step u_step (
		.data_byte (data_byte_s1),
		.is_signed (is_signed_s1),
		.max_bits  (max_bits_s1),
		.cur       (state_q),
		.res       (step)
	);

	// advance the input stage unless its result would overwrite a waiting one
	assign s1_adv   = valid_s1 && (!step.emit || !out_valid_q || result_ch.ready);
	assign byte_ch.ready = !valid_s1 || s1_adv;
	assign byte_acc = byte_ch.valid && byte_ch.ready;

	// input stage control, decoder state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1        <= 1'b0;
			state_q.acc     <= '0;
			state_q.bit_pos <= '0;
			state_q.sgn     <= 1'b0;
			state_q.limit   <= LimitMax;
			out_valid_q     <= 1'b0;
		end else begin
			if (byte_acc) begin
				valid_s1 <= 1'b1;
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
			if (s1_adv) begin
				state_q <= step.next;
			end
			if (s1_adv && step.emit) begin
				out_valid_q <= 1'b1;
			end else if (result_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// capture payloads
	always_ff @(posedge clk) begin
		if (byte_acc) begin
			data_byte_s1 <= byte_ch.data_byte;
			is_signed_s1 <= byte_ch.is_signed;
			max_bits_s1  <= byte_ch.max_bits;
		end
		if (s1_adv && step.emit) begin
			value_q  <= step.value;
			status_q <= step.status;
		end
	end

	assign result_ch.valid  = out_valid_q;
	assign result_ch.value  = value_q;
	assign result_ch.status = status_q;
endmodule

@@ dv/tb_leb128_stream_decoder_core.sv @@
// Self-checking testbench for leb128_stream_decoder_core: directed and random byte streams,
// random stalls on both channels, results checked in order against a built-in decoder.
// Depends on leb_pkg, leb_in_if, leb_out_if and the core RTL.
`timescale 1ns / 100ps

module tb_leb128_stream_decoder_core;
	import leb_pkg::*;

	localparam int unsigned WatchdogLimit = 500;
	localparam int unsigned ByteTarget    = 1250;

	typedef struct packed {
		logic [63:0] value;
		status_t     status;
	} result_t;

	typedef struct {
		logic [7:0] data;
		logic       sgn;
		logic [6:0] lim;
		bit         typed;
		result_t    res;
	} stim_row_t;

	logic clk;
	logic arst_n;

	leb_in_if  byte_if();
	leb_out_if res_if();

	leb128_stream_decoder_core DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.byte_ch  (byte_if),
		.result_ch(res_if)
	);

	// decoder shadow state
	logic [63:0] dec_acc = '0;
	int unsigned dec_pos = 0;
	logic        dec_sgn = 1'b0;
	int unsigned dec_lim = 64;

	result_t     expected_numbers[$];
	stim_row_t   directed_rows[$];

	// typed expectation travels with the request it belongs to
	bit          row_has_typed;
	result_t     row_typed_res;

	int unsigned bytes_sent;
	int unsigned bytes_accepted;
	int unsigned mismatches;
	int unsigned cnt_ok;
	int unsigned cnt_padding;
	int unsigned cnt_too_long;
	int unsigned drains;
	int unsigned quiet_cycles;
	int unsigned stall_left;
	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Append one expected result at the tail of the scoreboard.
	function automatic void queue_expected(input result_t r);
		expected_numbers = {expected_numbers, r};
	endfunction

	// Decode one byte into the shadow state; return 1 when a number closes.
	function automatic bit decode_byte(input logic [7:0] b, input logic s, input logic [6:0] m,
		output result_t res);
		int unsigned after;
		int unsigned top;
		logic [6:0]  pad;
		logic        neg;
		bit          done;
		res.value  = '0;
		res.status = ST_OK;
		done = 1'b0;
		if (dec_pos == 0) begin
			dec_lim = (m == 7'd0) ? 1 : ((m > 7'd64) ? 64 : int'(m));
			dec_sgn = s;
			dec_acc = '0;
		end
		// payload bits above bit 63 fall off the shift
		dec_acc = dec_acc | (64'(b[6:0]) << dec_pos);
		after = dec_pos + 7;
		// check unused high payload bits on the byte that crosses the limit
		if (after > dec_lim) begin
			top = 6 - (after - dec_lim);
			pad = 7'h7F << (top + 1);
			neg = dec_sgn && b[top];
			if ((b[6:0] & pad) != (neg ? pad : 7'h00)) begin
				res.status = ST_PADDING;
				done = 1'b1;
			end
		end
		if (!done && b[7]) begin
			if (after >= dec_lim) begin
				res.status = ST_TOO_LONG;
				done = 1'b1;
			end else begin
				dec_pos = after;
			end
		end else if (!done) begin
			res.value = dec_acc;
			if (dec_sgn && b[6] && after < 64)
				res.value = res.value | ({64{1'b1}} << after);
			done = 1'b1;
		end
		if (done) begin
			dec_pos = 0;
			dec_acc = '0;
		end
		return done;
	endfunction

	// Check results first, then predict from the byte accepted at the same edge.
	always @(posedge clk) begin
		result_t exp_res;
		result_t pred;
		if (arst_n) begin
			if (res_if.valid && res_if.ready) begin
				if (expected_numbers.size() == 0) begin
					$display("%0t: unexpected result: expected none, got value %h status %0d",
						$time, res_if.value, res_if.status);
					mismatches++;
				end else begin
					exp_res = expected_numbers.pop_front();
					case (exp_res.status)
						ST_OK:      cnt_ok++;
						ST_PADDING: cnt_padding++;
						default:    cnt_too_long++;
					endcase
					if (res_if.value !== exp_res.value) begin
						$display("%0t: value mismatch: expected %h, got %h",
							$time, exp_res.value, res_if.value);
						mismatches++;
					end
					if (res_if.status !== exp_res.status) begin
						$display("%0t: status mismatch: expected %0d, got %0d",
							$time, exp_res.status, res_if.status);
						mismatches++;
					end
				end
			end
			if (byte_if.valid && byte_if.ready) begin
				bytes_accepted++;
				if (decode_byte(byte_if.data_byte, byte_if.is_signed, byte_if.max_bits, pred))
					queue_expected(row_has_typed ? row_typed_res : pred);
			end
		end
	end

	// Result sink: drops ready in random stall bursts.
	always @(posedge clk) begin
		if (arst_n) begin
			if (stall_left > 0) begin
				res_if.ready <= 1'b0;
				stall_left <= stall_left - 1;
			end else if ($urandom_range(0, 99) < recv_stall_pct) begin
				res_if.ready <= 1'b0;
				stall_left <= $urandom_range(0, 6);
			end else begin
				res_if.ready <= 1'b1;
			end
		end
	end

	// Watchdog: end the run when no request moves for too long.
	always @(posedge clk) begin
		if ((byte_if.valid && byte_if.ready) || (res_if.valid && res_if.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WatchdogLimit) begin
				$display("%0t: watchdog: no request moved for %0d cycles", $time, quiet_cycles);
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// Offer one byte and hold it until accepted, then maybe idle.
	task automatic put_byte(input logic [7:0] b, input logic s, input logic [6:0] m,
		input bit has_typed, input result_t typed_res);
		byte_if.valid     <= 1'b1;
		byte_if.data_byte <= b;
		byte_if.is_signed <= s;
		byte_if.max_bits  <= m;
		row_has_typed     <= has_typed;
		row_typed_res     <= typed_res;
		do @(posedge clk); while (!byte_if.ready);
		bytes_sent++;
		if ($urandom_range(0, 99) < send_idle_pct) begin
			byte_if.valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
	endtask

	// Stop sending until every outstanding result has come back.
	task automatic hold_until_drained();
		byte_if.valid <= 1'b0;
		@(posedge clk);
		while (expected_numbers.size() != 0) @(posedge clk);
		drains++;
	endtask

	task automatic add_row(input logic [7:0] b, input logic s, input logic [6:0] m,
		input bit typed, input logic [63:0] val, input status_t st);
		stim_row_t row;
		row.data = b;
		row.sgn = s;
		row.lim = m;
		row.typed = typed;
		row.res.value = val;
		row.res.status = st;
		directed_rows = {directed_rows, row};
	endtask

	initial begin
		result_t     no_res;
		int unsigned n;
		int unsigned groups;
		int unsigned used;
		int unsigned kind;
		int unsigned numbers;
		int unsigned lim;
		logic        s;
		logic        sign;
		logic [6:0]  m;
		logic [6:0]  pl;
		logic [7:0]  seq [11];

		byte_if.valid     = 1'b0;
		byte_if.data_byte = '0;
		byte_if.is_signed = 1'b0;
		byte_if.max_bits  = 7'd64;
		res_if.ready      = 1'b0;
		row_has_typed     = 1'b0;
		row_typed_res     = '0;
		no_res            = '0;
		send_idle_pct     = 20;
		recv_stall_pct    = 15;
		arst_n            = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// data, signed, limit, typed?, value, status
		add_row(8'h00, 1'b0, 7'd64,  1, 64'h0, ST_OK);
		add_row(8'h7F, 1'b0, 7'd64,  1, 64'h7F, ST_OK);
		add_row(8'h7F, 1'b1, 7'd64,  1, {64{1'b1}}, ST_OK);
		add_row(8'h40, 1'b1, 7'd64,  1, 64'hFFFF_FFFF_FFFF_FFC0, ST_OK);
		add_row(8'h3F, 1'b1, 7'd64,  1, 64'h3F, ST_OK);
		// zero limit reads as one bit
		add_row(8'h01, 1'b0, 7'd0,   1, 64'h1, ST_OK);
		add_row(8'h02, 1'b0, 7'd0,   1, 64'h0, ST_PADDING);
		// limit above 64 reads as 64
		add_row(8'h85, 1'b0, 7'd127, 0, 64'h0, ST_OK);
		add_row(8'h01, 1'b0, 7'd127, 0, 64'h0, ST_OK);
		// continuation at the limit
		add_row(8'h81, 1'b0, 7'd7,   1, 64'h0, ST_TOO_LONG);
		// later bytes carry junk flag and limit that must be ignored
		add_row(8'h80, 1'b0, 7'd8,   0, 64'h0, ST_OK);
		add_row(8'h01, 1'b1, 7'd0,   0, 64'h0, ST_OK);
		add_row(8'h80, 1'b0, 7'd8,   0, 64'h0, ST_OK);
		add_row(8'h02, 1'b0, 7'd8,   1, 64'h0, ST_PADDING);
		// bad padding wins over too many bytes
		add_row(8'hC0, 1'b0, 7'd6,   1, 64'h0, ST_PADDING);
		// negative padding fine, but still too long
		add_row(8'hE0, 1'b1, 7'd6,   1, 64'h0, ST_TOO_LONG);
		add_row(8'h60, 1'b1, 7'd6,   0, 64'h0, ST_OK);
		add_row(8'h20, 1'b1, 7'd6,   1, 64'h0, ST_PADDING);
		add_row(8'hFF, 1'b0, 7'd14,  0, 64'h0, ST_OK);
		add_row(8'h7F, 1'b0, 7'd14,  0, 64'h0, ST_OK);

		foreach (directed_rows[i])
			put_byte(directed_rows[i].data, directed_rows[i].sgn, directed_rows[i].lim,
				directed_rows[i].typed, directed_rows[i].res);
		hold_until_drained();

		// random numbers: mostly well-formed, some corrupted, some noise
		numbers = 0;
		while (bytes_sent < ByteTarget) begin
			numbers++;
			if (numbers % 50 == 0 && bytes_sent <= ByteTarget - 150)
				hold_until_drained();
			if (bytes_sent > ByteTarget - 150) begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end else if (numbers % 30 == 0) begin
				send_idle_pct = $urandom_range(0, 1) ? 25 : 0;
				recv_stall_pct = $urandom_range(0, 1) ? 20 : 0;
			end
			s = $urandom_range(0, 1);
			kind = $urandom_range(0, 19);
			if (kind == 0)
				m = 7'd0;
			else if (kind == 1)
				m = $urandom_range(65, 127);
			else if (kind < 5)
				m = 7'd64;
			else
				m = $urandom_range(1, 64);
			lim = (m == 7'd0) ? 1 : ((m > 7'd64) ? 64 : int'(m));
			kind = $urandom_range(0, 99);
			if (kind < 15) begin
				n = $urandom_range(1, 11);
				for (int i = 0; i < n; i++)
					seq[i] = $urandom_range(0, 255);
			end else begin
				groups = (lim + 6) / 7;
				n = $urandom_range(0, 1) ? groups : $urandom_range(1, groups);
				for (int i = 0; i < n; i++) begin
					pl = $urandom_range(0, 127);
					used = lim - 7 * i;
					if (used > 7)
						used = 7;
					// pad the last byte to match the sign of its top used bit
					if (i == n - 1 && used < 7) begin
						sign = s && pl[used - 1];
						for (int k = used; k < 7; k++)
							pl[k] = sign;
					end
					seq[i] = {(i != n - 1), pl};
				end
				if (kind < 30)
					seq[$urandom_range(0, n - 1)] ^= 8'(1 << $urandom_range(0, 7));
			end
			for (int i = 0; i < n; i++) begin
				if (i == 0)
					put_byte(seq[i], s, m, 0, no_res);
				else
					put_byte(seq[i], $urandom_range(0, 1), $urandom_range(0, 127), 0, no_res);
			end
		end

		// drain and let the pipeline settle
		byte_if.valid <= 1'b0;
		while (expected_numbers.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);

		$display("Streamed %0d bytes; %0d numbers closed: %0d ok, %0d bad padding, %0d too long.",
			bytes_accepted, cnt_ok + cnt_padding + cnt_too_long, cnt_ok, cnt_padding,
			cnt_too_long);
		$display("Limits 1..64 plus out-of-range fields, signed and unsigned, %0d drain pauses.",
			drains);
		if (mismatches == 0 && expected_numbers.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
